// File: hdl/card_number_luhn_classifier_assert.svh
// assertion macros for the card number classifier top module
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_ASSERT_SVH

// condition that must hold at every clock edge outside reset
`define LCLS_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("lcls check failed");

// condition in one cycle implies a condition in the next cycle
`define LCLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcls check failed");

`endif

// File: hdl/lcls_pkg.sv
// types, constants and helper functions for the card number classifier
package lcls_pkg;

   // one digit request
   typedef struct packed {
      logic [3:0] digit;
      logic       last;
   } req_type;

   // one classification result
   typedef struct packed {
      logic [1:0] card_kind;
      logic       valid_res;
   } rsp_type;

   // brand codes
   typedef enum logic [1:0] {
      KIND_INVALID = 2'd0,
      KIND_VISA    = 2'd1,
      KIND_AMEX    = 2'd2,
      KIND_MASTER  = 2'd3
   } kind_type;

   // running state of the number being received
   typedef struct packed {
      logic [4:0] digit_count;
      logic [3:0] lead_digit;
      logic [3:0] second_digit;
      logic [3:0] sum_double_even_pos;
      logic [3:0] sum_double_odd_pos;
   } state_type;

   localparam logic [4:0] COUNT_MAX      = 5'd31;
   localparam logic [4:0] LEN_VISA_SHORT = 5'd13;
   localparam logic [4:0] LEN_AMEX       = 5'd15;
   localparam logic [4:0] LEN_LONG       = 5'd16;
   localparam logic [3:0] DIGIT_NINE     = 4'd9;
   localparam logic [4:0] TEN            = 5'd10;
   localparam logic [4:0] TWENTY         = 5'd20;
   localparam logic [4:0] THIRTY         = 5'd30;

   localparam state_type STATE_RESET = '0;

   // luhn doubling: 2d, less nine when above nine
   function automatic logic [4:0] doubled(input logic [3:0] d);
      logic [4:0] m;
      m = {d, 1'b0};
      if (m > {1'b0, DIGIT_NINE}) begin
         m = m - {1'b0, DIGIT_NINE};
      end
      return m;
   endfunction

   // remainder by ten of a value no greater than thirty
   function automatic logic [3:0] mod10(input logic [4:0] v);
      logic [4:0] r;
      if (v >= THIRTY) begin
         r = v - THIRTY;
      end else if (v >= TWENTY) begin
         r = v - TWENTY;
      end else if (v >= TEN) begin
         r = v - TEN;
      end else begin
         r = v;
      end
      return r[3:0];
   endfunction

   // brand from length and the first two digits
   function automatic kind_type brand_of(input logic [4:0] len, input logic [3:0] a,
                                         input logic [3:0] b);
      kind_type k;
      if ((len == LEN_VISA_SHORT || len == LEN_LONG) && a == 4'd4) begin
         k = KIND_VISA;
      end else if (len == LEN_AMEX && a == 4'd3 && (b == 4'd4 || b == 4'd7)) begin
         k = KIND_AMEX;
      end else if (len == LEN_LONG && a == 4'd5 && b >= 4'd1 && b <= 4'd5) begin
         k = KIND_MASTER;
      end else begin
         k = KIND_INVALID;
      end
      return k;
   endfunction

endpackage

// File: hdl/lcls_step.sv
// next state and result for one digit of a card number
module lcls_step (
   input  lcls_pkg::state_type state_cur,
   input  lcls_pkg::req_type   req,
   output lcls_pkg::state_type state_next,
   output lcls_pkg::rsp_type   rsp
);
   import lcls_pkg::*;

   logic [4:0] pos;
   logic [4:0] plain_add;
   logic [4:0] dbl_add;
   logic [4:0] even_add;
   logic [4:0] odd_add;
   state_type  upd;
   logic [3:0] sum_sel;
   kind_type   brand;
   kind_type   kind;

   // position of this digit and the two luhn contributions
   assign pos       = state_cur.digit_count;
   assign plain_add = {1'b0, req.digit};
   assign dbl_add   = doubled(req.digit);
   assign even_add  = pos[0] ? plain_add : dbl_add;
   assign odd_add   = pos[0] ? dbl_add : plain_add;

   // updated accumulators
   always_comb begin
      upd = state_cur;
      if (pos == 5'd0) begin
         upd.lead_digit = req.digit;
      end else if (pos == 5'd1) begin
         upd.second_digit = req.digit;
      end
      upd.sum_double_even_pos = mod10({1'b0, state_cur.sum_double_even_pos} + even_add);
      upd.sum_double_odd_pos  = mod10({1'b0, state_cur.sum_double_odd_pos} + odd_add);
      if (pos != COUNT_MAX) begin
         upd.digit_count = pos + 5'd1;
      end
   end

   // pick the sum whose doubling leaves the rightmost digit alone
   assign sum_sel = upd.digit_count[0] ? upd.sum_double_odd_pos : upd.sum_double_even_pos;
   assign brand   = brand_of(upd.digit_count, upd.lead_digit, upd.second_digit);
   assign kind    = (sum_sel != 4'd0) ? KIND_INVALID : brand;

   // result and state for the next number
   assign rsp.card_kind = kind;
   assign rsp.valid_res = (kind != KIND_INVALID);
   assign state_next    = req.last ? STATE_RESET : upd;

endmodule

// File: hdl/card_number_luhn_classifier.sv
// top level of the card number classifier with luhn check
// Digits of a card number enter one per request, most significant first, with
// last set on the final digit. One request is taken every cycle: each digit
// is held in an input register, then a single pass of logic updates the digit
// count, the first two digits and two mod-10 luhn sums and, on the final
// digit, loads the result register, which offers the result; other digits
// give no result. The only back-pressure is a final digit waiting while the
// result register still holds an untaken result. After each final digit the
// block is ready for a new number.
module card_number_luhn_classifier (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lcls_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output lcls_pkg::rsp_type rsp_data
);
   import lcls_pkg::*;
   `include "card_number_luhn_classifier_assert.svh"

   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_req_ff;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   step_rsp;
   logic      out_free;
   logic      s1_fire;
   logic      req_take;

   // step logic
   lcls_step u_step (
      .state_cur  (state_ff),
      .req        (s1_req_ff),
      .state_next (state_in),
      .rsp        (step_rsp)
   );

   // handshake control
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign s1_fire     = s1_valid_ff && (!s1_req_ff.last || out_free);
   assign req_stall   = s1_valid_ff && !s1_fire;
   assign req_take    = req_valid && !req_stall;
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   // result valid next value
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && s1_req_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
      if (s1_fire && s1_req_ff.last) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `LCLS_ASSERT_ALWAYS(a_valid_res_matches_kind, clock, reset,
      !rsp_valid_ff || (rsp_ff.valid_res == (rsp_ff.card_kind != KIND_INVALID)))
   `LCLS_ASSERT_NEXT(a_state_clear_after_final, clock, reset,
      s1_fire && s1_req_ff.last, state_ff == STATE_RESET)
   `LCLS_ASSERT_NEXT(a_result_after_final, clock, reset,
      s1_fire && s1_req_ff.last, rsp_valid_ff)
   `LCLS_ASSERT_NEXT(a_state_holds_when_idle, clock, reset,
      !s1_fire, $stable(state_ff))

endmodule

// File: dv/card_number_luhn_checker.sv
// checker for the card number classifier: predicts each verdict and compares it
module card_number_luhn_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  lcls_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  lcls_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                cards_passed
);
   import lcls_pkg::*;

   // predicted state of the number being received
   logic [4:0] digit_pos;
   logic [3:0] first_dig;
   logic [3:0] second_dig;
   logic [3:0] sum_even;
   logic [3:0] sum_odd;

   // verdicts predicted but not yet seen on the result port
   rsp_type verdicts[$];

   initial begin
      fail_count   = 0;
      pending      = 0;
      cards_passed = 0;
   end

   // digit value after luhn doubling
   function automatic logic [4:0] luhn_double(input logic [3:0] d);
      int m;
      m = 2 * int'(d);
      if (m > 9) begin
         m = m - 9;
      end
      return 5'(m);
   endfunction

   // running sum kept mod ten
   function automatic logic [3:0] add_mod10(input logic [3:0] a, input logic [4:0] b);
      int t;
      t = int'(a) + int'(b);
      return 4'(t % 10);
   endfunction

   // brand from the length and the first two digits
   function automatic kind_type brand_for(input logic [4:0] len, input logic [3:0] a,
                                          input logic [3:0] b);
      if ((len == 5'd13 || len == 5'd16) && a == 4'd4) begin
         return KIND_VISA;
      end
      if (len == 5'd15 && a == 4'd3 && (b == 4'd4 || b == 4'd7)) begin
         return KIND_AMEX;
      end
      if (len == 5'd16 && a == 4'd5 && b >= 4'd1 && b <= 4'd5) begin
         return KIND_MASTER;
      end
      return KIND_INVALID;
   endfunction

   task automatic clear_number();
      digit_pos  = '0;
      first_dig  = '0;
      second_dig = '0;
      sum_even   = '0;
      sum_odd    = '0;
   endtask

   // fold one accepted digit into the prediction, queue a verdict on the last
   task automatic take_digit(input req_type r);
      logic [4:0] len;
      logic [3:0] chosen;
      rsp_type    v;
      if (digit_pos == 5'd0) begin
         first_dig = r.digit;
      end else if (digit_pos == 5'd1) begin
         second_dig = r.digit;
      end
      if (!digit_pos[0]) begin
         sum_even = add_mod10(sum_even, luhn_double(r.digit));
         sum_odd  = add_mod10(sum_odd, {1'b0, r.digit});
      end else begin
         sum_even = add_mod10(sum_even, {1'b0, r.digit});
         sum_odd  = add_mod10(sum_odd, luhn_double(r.digit));
      end
      if (digit_pos != COUNT_MAX) begin
         digit_pos = digit_pos + 5'd1;
      end
      if (r.last) begin
         len    = digit_pos;
         // the rightmost digit is never doubled, so pick by length parity
         chosen = len[0] ? sum_odd : sum_even;
         v.card_kind = (chosen == 4'd0) ? brand_for(len, first_dig, second_dig)
                                        : KIND_INVALID;
         v.valid_res = (v.card_kind != KIND_INVALID);
         if (v.valid_res) begin
            cards_passed++;
         end
         verdicts.push_back(v);
         clear_number();
      end
   endtask

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("mismatch: %s: expected kind %0d valid %0b, got kind %0d valid %0b",
                  what, want.card_kind, want.valid_res, got.card_kind, got.valid_res);
      end
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         clear_number();
         verdicts.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdicts.size() == 0) begin
               note_failure("result with no request waiting", '0, rsp_data);
            end else begin
               want = verdicts.pop_front();
               if (rsp_data.card_kind != want.card_kind) begin
                  note_failure("card_kind", want, rsp_data);
               end else if (rsp_data.valid_res != want.valid_res) begin
                  note_failure("valid_res", want, rsp_data);
               end
            end
         end
         if (req_valid && !req_stall) begin
            take_digit(req_data);
         end
      end
      pending = verdicts.size();
   end

endmodule

// File: dv/tb.sv
// testbench top for the card number classifier: clock, reset, stimulus and verdict
module tb;
   import lcls_pkg::*;

   localparam int DIGIT_TARGET = 1300;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 200000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int cards_passed;

   int cycles       = 0;
   int digits_sent  = 0;
   int numbers_sent = 0;
   int long_numbers = 0;
   bit gapless      = 1'b0;
   bit hold_req     = 1'b0;
   int held         = 0;

   card_number_luhn_classifier u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   card_number_luhn_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .cards_passed (cards_passed)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d verdicts outstanding", cycles, pending);
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side: one long hold-off on request, no stalls in the gapless stretch, otherwise random stalls
   always @(negedge clock) begin
      if (hold_req && held < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         held++;
      end else if (gapless) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 37);
      end
   end

   // offer one digit request and wait for it to be taken; entered at a falling edge
   task automatic send_digit(input logic [3:0] d, input logic fin);
      while (!gapless && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data.digit <= d;
      req_data.last  <= fin;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      digits_sent++;
   endtask

   // brand shapes for generated numbers
   typedef enum int { SHAPE_ANY, SHAPE_VISA, SHAPE_AMEX, SHAPE_MASTER } shape_type;

   // build a number of the given shape, optionally with a correct check digit
   task automatic send_number(input int len, input shape_type shape, input bit make_good);
      logic [3:0] dg [0:39];
      int s;
      int m;
      for (int i = 0; i < 40; i++) begin
         dg[i] = 4'($urandom_range(9));
      end
      case (shape)
         SHAPE_VISA: begin
            dg[0] = 4'd4;
         end
         SHAPE_AMEX: begin
            dg[0] = 4'd3;
            dg[1] = $urandom_range(1) ? 4'd4 : 4'd7;
         end
         SHAPE_MASTER: begin
            dg[0] = 4'd5;
            dg[1] = 4'($urandom_range(1, 5));
         end
         default: begin
         end
      endcase
      // now and then a digit above nine somewhere in the body
      if (len > 1 && $urandom_range(19) == 0) begin
         dg[$urandom_range(len - 2)] = 4'($urandom_range(10, 15));
      end
      if (make_good && len > 1) begin
         s = 0;
         for (int i = 0; i < len - 1; i++) begin
            m = int'(dg[i]);
            if ((len - 1 - i) % 2 == 1) begin
               m = 2 * m;
               if (m > 9) begin
                  m = m - 9;
               end
            end
            s += m;
         end
         dg[len - 1] = 4'((10 - s % 10) % 10);
      end
      for (int i = 0; i < len; i++) begin
         send_digit(dg[i], i == len - 1);
      end
      numbers_sent++;
      if (len > 16) begin
         long_numbers++;
      end
   endtask

   // mostly well-formed brand numbers, with near misses and odd lengths
   task automatic send_random_number();
      int pick;
      bit good;
      pick = $urandom_range(99);
      good = ($urandom_range(99) < 65);
      if (pick < 20) begin
         send_number($urandom_range(1) ? 13 : 16, SHAPE_VISA, good);
      end else if (pick < 35) begin
         send_number($urandom_range(3) == 0 ? $urandom_range(14, 16) : 15, SHAPE_AMEX, good);
      end else if (pick < 50) begin
         send_number($urandom_range(3) == 0 ? $urandom_range(15, 17) : 16, SHAPE_MASTER,
                     good);
      end else if (pick < 60) begin
         send_number($urandom_range(12, 17), SHAPE_VISA, good);
      end else if (pick < 63) begin
         send_number($urandom_range(17, 40), SHAPE_ANY, good);
      end else begin
         send_number($urandom_range(1, 20), SHAPE_ANY, good);
      end
   endtask

   // stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single-digit numbers at the digit extremes
      send_digit(4'd0, 1'b1);
      send_digit(4'd15, 1'b1);
      // short visa with a good check sum
      for (int i = 0; i < 13; i++) begin
         send_digit((i == 0) ? 4'd4 : 4'd2, i == 12);
      end
      // digit above nine in the prefix, then a two-digit number of nines
      send_digit(4'd10, 1'b0);
      send_digit(4'd5, 1'b1);
      send_digit(4'd9, 1'b0);
      send_digit(4'd9, 1'b1);
      numbers_sent += 5;

      while (digits_sent < 450) begin
         send_random_number();
      end

      // stretch with no idling on either side
      gapless = 1'b1;
      while (digits_sent < 650) begin
         send_random_number();
      end
      gapless = 1'b0;

      // long receiver hold-off while short numbers keep coming
      hold_req = 1'b1;
      for (int n = 0; n < 25; n++) begin
         send_number($urandom_range(1, 3), SHAPE_ANY, 1'b0);
      end
      hold_req = 1'b0;

      while (digits_sent < DIGIT_TARGET) begin
         send_random_number();
      end
      req_valid <= 1'b0;

      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);

      $display("sent %0d digits in %0d numbers (%0d longer than sixteen), %0d valid cards",
               digits_sent, numbers_sent, long_numbers, cards_passed);
      $display("random idling on both sides, a gapless stretch and a %0d-cycle result hold-off",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/lcls_pkg.sv
hdl/lcls_step.sv
hdl/card_number_luhn_classifier.sv
dv/card_number_luhn_checker.sv
dv/tb.sv
